FILE: rtl/core/wwr_pkg.sv
// ----------------------------------------------------------------------------
// wwr_pkg: shared definitions for the whole-word replace stream
// Widths, byte codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package wwr_pkg;

  localparam int WORD_MAX_DEF = 32;
  localparam int CHAR_W       = 8;
  localparam int LEN_W        = 4;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;
  localparam logic [LEN_W-1:0]  MAX_BYTES  = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_WORD = 2'd0,
    CFG_TARGET_LEN  = 2'd1,
    CFG_REPL_WORD   = 2'd2,
    CFG_REPL_LEN    = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_CMP_RD,
    S_CMP_CK,
    S_SEP,
    S_REPL,
    S_COPY_RD,
    S_COPY_WR,
    S_DONE,
    S_TERM
  } state_t;

endpackage

FILE: rtl/core/wwr_in_if.sv
// ----------------------------------------------------------------------------
// wwr_in_if: input byte channel
// Valid/ready channel carrying one sentence byte or an end marker.
// ----------------------------------------------------------------------------
interface wwr_in_if;
  logic                      valid;
  logic                      ready;
  logic [wwr_pkg::CHAR_W-1:0] in_char;
  logic                      sentence_end;

  modport source (output valid, output in_char, output sentence_end, input ready);
  modport sink   (input valid, input in_char, input sentence_end, output ready);
endinterface

FILE: rtl/core/wwr_out_if.sv
// ----------------------------------------------------------------------------
// wwr_out_if: output byte channel
// Valid/ready channel carrying one emitted byte or a terminator.
// ----------------------------------------------------------------------------
interface wwr_out_if;
  logic                      valid;
  logic                      ready;
  logic [wwr_pkg::CHAR_W-1:0] out_char;
  logic                      char_valid;
  logic                      last;
  logic                      word_overflow;

  modport source (output valid, output out_char, output char_valid, output last,
                  output word_overflow, input ready);
  modport sink   (input valid, input out_char, input char_valid, input last,
                  input word_overflow, output ready);
endinterface

FILE: rtl/core/wwr_ram.sv
// ----------------------------------------------------------------------------
// wwr_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/whole_word_replace_stream.sv
// ----------------------------------------------------------------------------
// whole_word_replace_stream: whole-word find and replace over a byte stream
// Buffers each word, compares it to a target and emits it or a replacement.
// ----------------------------------------------------------------------------
// Bytes of a sentence arrive one item at a time, closed by an item with
// sentence_end set. Spaces split words; each word is kept in a WORD_MAX-byte
// buffer RAM. A word whose length and bytes equal the target (up to 8 bytes,
// first byte lowest) comes out as the replacement, any other word as it was
// received. Words leave separated by one space, a sentence that opens with a
// space yields one empty word, and every sentence ends with a bare item
// (char_valid 0, last 1). Bytes beyond WORD_MAX are dropped and the word's
// bytes carry word_overflow. Word bytes are taken while the sequencer is
// idle. A space or end marker that closes a word holds off input while the
// word is sent: the sequencer checks the length, compares each target byte
// (buffer RAM read, then compare), passes the separator step, emits each
// replacement byte or each buffered byte (RAM read, then load), closes the
// word and, after an end marker, emits the terminator. The single buffer
// RAM read port sets this read-then-use order. Output stalls hold the
// sequencer in each step that emits a byte. Configuration may be written
// while no sentence output is pending; length values above 8 act as 8.
// ----------------------------------------------------------------------------
module whole_word_replace_stream #(
  parameter int WORD_MAX = wwr_pkg::WORD_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wwr_in_if.sink                         in_ch,
  wwr_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [wwr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wwr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(WORD_MAX);
  localparam int FILL_W = $clog2(WORD_MAX + 1);
  localparam int CW     = wwr_pkg::CHAR_W;
  localparam int LW     = wwr_pkg::LEN_W;
  localparam int DW     = wwr_pkg::CFG_DATA_W;

  // Configuration registers
  logic [DW-1:0] target_word_r;
  logic [LW-1:0] target_len_r;
  logic [DW-1:0] repl_word_r;
  logic [LW-1:0] repl_len_r;

  // Sentence state
  wwr_pkg::state_t state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic open_r, open_nxt;
  logic first_r, first_nxt;      // no word of this sentence sent yet
  logic start_r, start_nxt;      // no byte of this sentence seen yet
  logic trunc_r, trunc_nxt;
  logic end_pend_r, end_pend_nxt;
  logic match_r, match_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_char_r, out_char_nxt;
  logic          out_cv_r, out_cv_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  // Buffer RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [CW-1:0]     ram_rdata;

  logic              accept;
  logic              slot_free;
  logic [LW-1:0]     tl_sat;
  logic [LW-1:0]     rl_sat;
  logic [FILL_W-1:0] tl_ext;
  logic [FILL_W-1:0] rl_ext;
  logic [FILL_W-1:0] idx_inc;
  logic [5:0]        byte_sh;
  logic [DW-1:0]     tgt_shift;
  logic [DW-1:0]     repl_shift;
  logic [CW-1:0]     tgt_byte;
  logic [CW-1:0]     repl_byte;

  wwr_ram #(
    .WIDTH (CW),
    .DEPTH (WORD_MAX)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.in_char),
    .re    (ram_re),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == wwr_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  // Saturate lengths at eight bytes
  assign tl_sat  = (target_len_r > wwr_pkg::MAX_BYTES) ? wwr_pkg::MAX_BYTES : target_len_r;
  assign rl_sat  = (repl_len_r > wwr_pkg::MAX_BYTES) ? wwr_pkg::MAX_BYTES : repl_len_r;
  assign tl_ext  = FILL_W'(tl_sat);
  assign rl_ext  = FILL_W'(rl_sat);
  assign idx_inc = idx_r + 1'b1;

  // Byte select from the packed words (index stays below eight there)
  assign byte_sh    = {idx_r[2:0], 3'b000};
  assign tgt_shift  = target_word_r >> byte_sh;
  assign repl_shift = repl_word_r >> byte_sh;
  assign tgt_byte   = tgt_shift[CW-1:0];
  assign repl_byte  = repl_shift[CW-1:0];

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_char      = out_char_r;
  assign out_ch.char_valid    = out_cv_r;
  assign out_ch.last          = out_last_r;
  assign out_ch.word_overflow = out_ovf_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_word_r <= '0;
      target_len_r  <= '0;
      repl_word_r   <= '0;
      repl_len_r    <= '0;
    end else if (cfg_we) begin
      case (wwr_pkg::cfg_reg_t'(cfg_index))
        wwr_pkg::CFG_TARGET_WORD: target_word_r <= cfg_wdata;
        wwr_pkg::CFG_TARGET_LEN:  target_len_r  <= cfg_wdata[LW-1:0];
        wwr_pkg::CFG_REPL_WORD:   repl_word_r   <= cfg_wdata;
        wwr_pkg::CFG_REPL_LEN:    repl_len_r    <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wwr_pkg::S_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      open_r      <= 1'b0;
      first_r     <= 1'b1;
      start_r     <= 1'b1;
      trunc_r     <= 1'b0;
      end_pend_r  <= 1'b0;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      open_r      <= open_nxt;
      first_r     <= first_nxt;
      start_r     <= start_nxt;
      trunc_r     <= trunc_nxt;
      end_pend_r  <= end_pend_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload needs no reset
  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_cv_r   <= out_cv_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    open_nxt      = open_r;
    first_nxt     = first_r;
    start_nxt     = start_r;
    trunc_nxt     = trunc_r;
    end_pend_nxt  = end_pend_r;
    match_nxt     = match_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_cv_nxt    = out_cv_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = fill_r[ADDR_W-1:0];
    ram_re        = 1'b0;

    case (state_r)
      wwr_pkg::S_IDLE: begin
        if (accept) begin
          if (in_ch.sentence_end) begin
            // Flush any open word, then terminate
            end_pend_nxt = 1'b1;
            state_nxt    = open_r ? wwr_pkg::S_CHECK : wwr_pkg::S_TERM;
          end else if (in_ch.in_char == wwr_pkg::SPACE_CHAR) begin
            end_pend_nxt = 1'b0;
            start_nxt    = 1'b0;
            if (open_r || start_r) begin
              state_nxt = wwr_pkg::S_CHECK;
            end
          end else begin
            // Store the byte, or drop it past the buffer end
            if (fill_r < FILL_W'(WORD_MAX)) begin
              ram_we   = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end else begin
              trunc_nxt = 1'b1;
            end
            open_nxt  = 1'b1;
            start_nxt = 1'b0;
          end
        end
      end

      wwr_pkg::S_CHECK: begin
        idx_nxt = '0;
        if (trunc_r || (fill_r != tl_ext)) begin
          match_nxt = 1'b0;
          state_nxt = wwr_pkg::S_SEP;
        end else if (tl_sat == '0) begin
          match_nxt = 1'b1;
          state_nxt = wwr_pkg::S_SEP;
        end else begin
          state_nxt = wwr_pkg::S_CMP_RD;
        end
      end

      wwr_pkg::S_CMP_RD: begin
        ram_re    = 1'b1;
        state_nxt = wwr_pkg::S_CMP_CK;
      end

      wwr_pkg::S_CMP_CK: begin
        if (ram_rdata != tgt_byte) begin
          match_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = wwr_pkg::S_SEP;
        end else if (idx_inc == tl_ext) begin
          match_nxt = 1'b1;
          idx_nxt   = '0;
          state_nxt = wwr_pkg::S_SEP;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = wwr_pkg::S_CMP_RD;
        end
      end

      wwr_pkg::S_SEP: begin
        idx_nxt = '0;
        if (first_r || slot_free) begin
          if (!first_r) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = wwr_pkg::SPACE_CHAR;
            out_cv_nxt    = 1'b1;
            out_last_nxt  = 1'b0;
            out_ovf_nxt   = 1'b0;
          end
          if (match_r) begin
            state_nxt = (rl_sat == '0) ? wwr_pkg::S_DONE : wwr_pkg::S_REPL;
          end else begin
            state_nxt = (fill_r == '0) ? wwr_pkg::S_DONE : wwr_pkg::S_COPY_RD;
          end
        end
      end

      wwr_pkg::S_REPL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = repl_byte;
          out_cv_nxt    = 1'b1;
          out_last_nxt  = 1'b0;
          out_ovf_nxt   = trunc_r;
          idx_nxt       = idx_inc;
          if (idx_inc == rl_ext) begin
            state_nxt = wwr_pkg::S_DONE;
          end
        end
      end

      wwr_pkg::S_COPY_RD: begin
        ram_re    = 1'b1;
        state_nxt = wwr_pkg::S_COPY_WR;
      end

      wwr_pkg::S_COPY_WR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ram_rdata;
          out_cv_nxt    = 1'b1;
          out_last_nxt  = 1'b0;
          out_ovf_nxt   = trunc_r;
          idx_nxt       = idx_inc;
          state_nxt     = (idx_inc == fill_r) ? wwr_pkg::S_DONE : wwr_pkg::S_COPY_RD;
        end
      end

      wwr_pkg::S_DONE: begin
        fill_nxt  = '0;
        open_nxt  = 1'b0;
        trunc_nxt = 1'b0;
        first_nxt = 1'b0;
        state_nxt = end_pend_r ? wwr_pkg::S_TERM : wwr_pkg::S_IDLE;
      end

      wwr_pkg::S_TERM: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = wwr_pkg::NUL_CHAR;
          out_cv_nxt    = 1'b0;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = 1'b0;
          // Return to the start-of-sentence state
          fill_nxt      = '0;
          open_nxt      = 1'b0;
          first_nxt     = 1'b1;
          start_nxt     = 1'b1;
          trunc_nxt     = 1'b0;
          end_pend_nxt  = 1'b0;
          state_nxt     = wwr_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = wwr_pkg::S_IDLE;
      end
    endcase
  end

endmodule
